>>> hdl/semaphore_round_robin_wake_assert.svh
// Assertion macros for the semaphore table checker.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef SEMAPHORE_ROUND_ROBIN_WAKE_ASSERT_SVH
`define SEMAPHORE_ROUND_ROBIN_WAKE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SRRW_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SRRW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/srrw_pkg.sv
// Shared types and constants for the semaphore table.
// No dependencies.
package srrw_pkg;

  localparam int FUNC_W = 2;
  localparam int SID_W  = 3;
  localparam int CNT_W  = 7;
  localparam int PID_W  = 3;
  localparam int MASK_W = 8;

  localparam logic [FUNC_W-1:0] FUNC_INIT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POST = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_WAIT = 2'd2;

  localparam logic [CNT_W-1:0] COUNT_MAX = 7'd127;

  localparam int QUEUE_DEPTH = 2;

  // decoded operation; NOP covers unused func codes and absent semaphores
  typedef enum logic [1:0] {
    OP_NOP,
    OP_INIT,
    OP_POST,
    OP_WAIT
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [SID_W-1:0] sem;
    logic [CNT_W-1:0] init_value;
    logic [PID_W-1:0] proc;
    logic             proc_ok;
  } cmd_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SCAN
  } back_state_t;

endpackage

>>> hdl/srrw_front.sv
// Front end: accepts requests, classifies them into commands, holds one.
// Depends on srrw_pkg.
module srrw_front #(
  parameter int NUM_SEMS  = 8,
  parameter int NUM_PROCS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [srrw_pkg::FUNC_W-1:0] in_func,
  input  logic [srrw_pkg::SID_W-1:0]  in_sem_id,
  input  logic [srrw_pkg::CNT_W-1:0]  in_init_value,
  input  logic [srrw_pkg::PID_W-1:0]  in_process_id,
  output logic                        push_valid,
  input  logic                        push_ready,
  output srrw_pkg::cmd_t              push_cmd
);
  import srrw_pkg::*;

  logic front_v_r;
  cmd_t cmd_r;
  cmd_t cmd_nxt;
  logic sem_ok;
  logic take;

  assign sem_ok = 32'(in_sem_id) < NUM_SEMS;

  always_comb begin
    cmd_nxt.sem        = in_sem_id;
    cmd_nxt.init_value = in_init_value;
    cmd_nxt.proc       = in_process_id;
    cmd_nxt.proc_ok    = 32'(in_process_id) < NUM_PROCS;
    unique case (in_func)
      FUNC_INIT: cmd_nxt.op = OP_INIT;
      FUNC_POST: cmd_nxt.op = OP_POST;
      FUNC_WAIT: cmd_nxt.op = OP_WAIT;
      default:   cmd_nxt.op = OP_NOP;
    endcase
    if (!sem_ok) begin
      cmd_nxt.op = OP_NOP;
    end
  end

  assign in_stall   = front_v_r && !push_ready;
  assign take       = in_valid && !in_stall;
  assign push_valid = front_v_r;
  assign push_cmd   = cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_v_r <= 1'b0;
    end else if (take) begin
      front_v_r <= 1'b1;
    end else if (push_ready) begin
      front_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

>>> hdl/srrw_queue.sv
// Short command queue between front end and back end.
// Depends on srrw_pkg.
module srrw_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  srrw_pkg::cmd_t push_cmd,
  output logic           head_valid,
  input  logic           pop,
  output srrw_pkg::cmd_t head_cmd
);
  import srrw_pkg::*;

  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          mem_r [QUEUE_DEPTH];
  logic [QW-1:0] wr_r;
  logic [QW-1:0] rd_r;
  logic [CW-1:0] cnt_r;
  logic          do_push;
  logic          do_pop;

  function automatic logic [QW-1:0] ptr_inc(input logic [QW-1:0] p);
    ptr_inc = (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + QW'(1);
  endfunction

  assign push_ready = cnt_r != CW'(QUEUE_DEPTH);
  assign head_valid = cnt_r != '0;
  assign head_cmd   = mem_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= ptr_inc(wr_r);
      end
      if (do_pop) begin
        rd_r <= ptr_inc(rd_r);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_cmd;
    end
  end

endmodule

>>> hdl/srrw_back.sv
// Back end: semaphore state, round-robin waiter scan, result register.
// Depends on srrw_pkg.
module srrw_back #(
  parameter int NUM_SEMS  = 8,
  parameter int NUM_PROCS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  srrw_pkg::cmd_t              q_cmd,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_granted,
  output logic                        out_woke_valid,
  output logic [srrw_pkg::PID_W-1:0]  out_woke_process,
  output logic [srrw_pkg::MASK_W-1:0] out_blocked_mask
);
  import srrw_pkg::*;

  // only semaphores reachable through the id field need storage
  localparam int SEM_DEPTH = (NUM_SEMS < 2 ** SID_W) ? NUM_SEMS : 2 ** SID_W;
  localparam int SEM_IW    = (SEM_DEPTH > 1) ? $clog2(SEM_DEPTH) : 1;
  localparam int PW        = $clog2(NUM_PROCS);

  back_state_t state_r, state_nxt;

  logic [CNT_W-1:0]     cnt_r  [SEM_DEPTH];
  logic [NUM_PROCS-1:0] wait_r [SEM_DEPTH];
  logic [PW-1:0]        last_r [SEM_DEPTH];
  logic [NUM_PROCS-1:0] blk_r;

  logic [SEM_IW-1:0] cur_sem_r;
  logic [PW-1:0]     scan_p_r;

  logic              out_valid_r;
  logic              out_granted_r;
  logic              out_woke_valid_r;
  logic [PID_W-1:0]  out_woke_process_r;
  logic [MASK_W-1:0] out_blocked_r;

  logic                 out_free;
  logic [SEM_IW-1:0]    si_head;
  logic [PW-1:0]        pi_head;
  logic [CNT_W-1:0]     head_cnt;
  logic [NUM_PROCS-1:0] head_wait;
  logic [PW-1:0]        head_last;
  logic [PW-1:0]        head_start;
  logic                 needs_scan;
  logic [NUM_PROCS-1:0] cur_wait;
  logic                 hit;
  logic [PW-1:0]        scan_p_next;
  logic [NUM_PROCS-1:0] p_bit;
  logic [NUM_PROCS-1:0] wake_bit;
  logic                 exec_granted;
  logic                 exec_block;
  logic [NUM_PROCS-1:0] exec_blk;
  logic [NUM_PROCS-1:0] wake_blk;

  logic exec_now;
  logic start_scan;
  logic wake_now;
  logic advance;

  assign out_free    = !out_valid_r || !out_stall;
  assign si_head     = q_cmd.sem[SEM_IW-1:0];
  assign pi_head     = q_cmd.proc[PW-1:0];
  assign head_cnt    = cnt_r[si_head];
  assign head_wait   = wait_r[si_head];
  assign head_last   = last_r[si_head];
  assign head_start  = (head_last == PW'(NUM_PROCS - 1)) ? '0 : head_last + PW'(1);
  assign needs_scan  = (q_cmd.op == OP_POST) && (head_wait != '0);
  assign cur_wait    = wait_r[cur_sem_r];
  assign hit         = cur_wait[scan_p_r];
  assign scan_p_next = (scan_p_r == PW'(NUM_PROCS - 1)) ? '0 : scan_p_r + PW'(1);

  assign p_bit        = NUM_PROCS'(1) << pi_head;
  assign wake_bit     = NUM_PROCS'(1) << scan_p_r;
  assign exec_granted = (q_cmd.op == OP_WAIT) && (head_cnt != '0);
  assign exec_block   = (q_cmd.op == OP_WAIT) && (head_cnt == '0) && q_cmd.proc_ok;
  assign exec_blk     = exec_block ? (blk_r | p_bit) : blk_r;
  assign wake_blk     = blk_r & ~wake_bit;

  // control outputs
  always_comb begin
    q_pop      = 1'b0;
    exec_now   = 1'b0;
    start_scan = 1'b0;
    wake_now   = 1'b0;
    advance    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          if (needs_scan) begin
            start_scan = 1'b1;
          end else begin
            exec_now = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (!hit) begin
          advance = 1'b1;
        end else if (out_free) begin
          wake_now = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start_scan) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (wake_now) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      blk_r   <= '0;
      for (int s = 0; s < SEM_DEPTH; s++) begin
        cnt_r[s]  <= '0;
        wait_r[s] <= '0;
        last_r[s] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (exec_now) begin
        unique case (q_cmd.op)
          OP_INIT: begin
            cnt_r[si_head]  <= q_cmd.init_value;
            wait_r[si_head] <= '0;
            last_r[si_head] <= '0;
          end
          OP_POST: begin
            if (head_cnt != COUNT_MAX) begin
              cnt_r[si_head] <= head_cnt + CNT_W'(1);
            end
          end
          OP_WAIT: begin
            if (exec_granted) begin
              cnt_r[si_head] <= head_cnt - CNT_W'(1);
            end else if (exec_block) begin
              wait_r[si_head] <= head_wait | p_bit;
            end
          end
          OP_NOP: ;
          default: ;
        endcase
        blk_r <= exec_blk;
      end
      if (wake_now) begin
        wait_r[cur_sem_r] <= cur_wait & ~wake_bit;
        last_r[cur_sem_r] <= scan_p_r;
        blk_r             <= wake_blk;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_scan) begin
      cur_sem_r <= si_head;
      scan_p_r  <= head_start;
    end else if (advance) begin
      scan_p_r <= scan_p_next;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_now || wake_now) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_now) begin
      out_granted_r      <= exec_granted;
      out_woke_valid_r   <= 1'b0;
      out_woke_process_r <= '0;
      out_blocked_r      <= MASK_W'(exec_blk);
    end else if (wake_now) begin
      out_granted_r      <= 1'b0;
      out_woke_valid_r   <= 1'b1;
      out_woke_process_r <= PID_W'(scan_p_r);
      out_blocked_r      <= MASK_W'(wake_blk);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_granted      = out_granted_r;
  assign out_woke_valid   = out_woke_valid_r;
  assign out_woke_process = out_woke_process_r;
  assign out_blocked_mask = out_blocked_r;

endmodule

>>> hdl/semaphore_round_robin_wake.sv
// Top level of the counting semaphore table with round-robin wake-up.
// Depends on srrw_pkg, srrw_front, srrw_queue, srrw_back.
//
//   channel | ports                                                | role
//   --------+------------------------------------------------------+-------------------
//   in      | in_valid in_stall in_func in_sem_id in_init_value    | one request
//           | in_process_id                                        |
//   out     | out_valid out_stall out_granted out_woke_valid       | one result/request
//           | out_woke_process out_blocked_mask                    |
//
// Init, wait, post with no waiters and ignored requests need no back-end scan, so a
// steady stream of them moves at one request per cycle while out_stall is low.
// Post on a semaphore with waiters: the back end scans waiter bits one per cycle,
// starting after the last process woken, until it finds a waiter to wake.
// Reset (rst_n low, synchronous) clears all counts, waiter sets, pointers and
// the blocked mask at once; no clearing pass.
// out_stall holds the result register; the two-entry queue and front register
// keep taking requests until they fill, then in_stall rises.
module semaphore_round_robin_wake #(
  parameter int NUM_SEMS  = 8,
  parameter int NUM_PROCS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [srrw_pkg::FUNC_W-1:0] in_func,
  input  logic [srrw_pkg::SID_W-1:0]  in_sem_id,
  input  logic [srrw_pkg::CNT_W-1:0]  in_init_value,
  input  logic [srrw_pkg::PID_W-1:0]  in_process_id,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_granted,
  output logic                        out_woke_valid,
  output logic [srrw_pkg::PID_W-1:0]  out_woke_process,
  output logic [srrw_pkg::MASK_W-1:0] out_blocked_mask
);
  import srrw_pkg::*;

  // front -> queue
  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;

  // queue -> back
  logic head_valid;
  logic head_pop;
  cmd_t head_cmd;

  // classify: unused func codes and absent semaphores become no-ops
  srrw_front #(
    .NUM_SEMS  (NUM_SEMS),
    .NUM_PROCS (NUM_PROCS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_sem_id     (in_sem_id),
    .in_init_value (in_init_value),
    .in_process_id (in_process_id),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_cmd      (push_cmd)
  );

  // decouples classification from the multi-cycle waiter scan
  srrw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .head_valid (head_valid),
    .pop        (head_pop),
    .head_cmd   (head_cmd)
  );

  // executes commands in order against the semaphore state
  srrw_back #(
    .NUM_SEMS  (NUM_SEMS),
    .NUM_PROCS (NUM_PROCS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (head_valid),
    .q_cmd            (head_cmd),
    .q_pop            (head_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_granted      (out_granted),
    .out_woke_valid   (out_woke_valid),
    .out_woke_process (out_woke_process),
    .out_blocked_mask (out_blocked_mask)
  );

endmodule

>>> hdl/srrw_checker.sv
// Port-level checks for the semaphore table, bound to the top level.
// Depends on srrw_pkg and semaphore_round_robin_wake_assert.svh.
`include "semaphore_round_robin_wake_assert.svh"

module srrw_checker #(
  parameter int NUM_PROCS = 8
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        out_granted,
  input logic                        out_woke_valid,
  input logic [srrw_pkg::PID_W-1:0]  out_woke_process,
  input logic [srrw_pkg::MASK_W-1:0] out_blocked_mask
);
  import srrw_pkg::*;

  `SRRW_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_granted) && $stable(out_woke_valid) && $stable(out_woke_process) && $stable(out_blocked_mask), "result changed while stalled")
  `SRRW_ASSERT_SAME(a_grant_xor_wake, out_valid, !(out_granted && out_woke_valid), "grant and wake in one result")
  `SRRW_ASSERT_SAME(a_woken_unblocked, out_valid && out_woke_valid, !out_blocked_mask[out_woke_process], "woken process still blocked")
  `SRRW_ASSERT_SAME(a_no_wake_zero_id, out_valid && !out_woke_valid, out_woke_process == '0, "woke_process set without a wake")
  `SRRW_ASSERT_SAME(a_mask_in_range, out_valid, (out_blocked_mask >> NUM_PROCS) == '0, "blocked bit beyond process count")

endmodule

bind semaphore_round_robin_wake srrw_checker #(
  .NUM_PROCS (NUM_PROCS)
) u_srrw_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_granted      (out_granted),
  .out_woke_valid   (out_woke_valid),
  .out_woke_process (out_woke_process),
  .out_blocked_mask (out_blocked_mask)
);
